// ----- design/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted table search package
// Opcodes, sequencer states, field widths and register indexes shared by the
// sorted table search block and its checker.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 8;
    localparam int FIELD_W  = 32;
    localparam int END_W    = 9;
    localparam int COUNT_W  = 9;
    localparam int POS_W    = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Register index of element_count in the configuration space.
    localparam int REG_ELEMENT_COUNT = 0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE      = 2'd0,
        OP_BIN_SEARCH = 2'd1,
        OP_EXP_SEARCH = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIN_PROBE,
        ST_BIN_CMP,
        ST_EXP_FIRST,
        ST_EXP_PROBE,
        ST_EXP_CMP,
        ST_EXP_SPLIT,
        ST_DONE
    } t_state;

endpackage

// ----- design/sts_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sorted_table_exponential_search.sv -----
// ----------------------------------------------------------------------------
// Sorted table with binary and exponential search
// Holds an ascending table of signed words and searches it for a key.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions on i_valid/o_ready carry an opcode. A write stores
// i_write_value at i_write_index and gives no result. A binary
// search looks for i_search_key between i_range_start and i_range_end; an
// exponential search checks entry 0, doubles a probe index while it is below
// element_count and its entry is at most the key, then binary-searches the
// last interval. Each search gives one result transaction on o_valid/i_ready.
// Every probe drives the address in a probe state and compares the registered
// read data in a compare state, on one read port. An exponential search first
// compares entry 0, then runs its doubling probes, a last loop test when the
// index reaches element_count, and a step that sets up the last interval.
// o_ready is high only while the sequencer is idle. A finished result waits
// in the output register while the receiver stalls, and the next transaction
// is accepted meanwhile. Reset clears the sequencer, the output valid flag and
// element_count; the table is undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_exponential_search #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [sts_pkg::OPCODE_W-1:0]         i_opcode,
    input  logic [sts_pkg::INDEX_W-1:0]          i_write_index,
    input  logic signed [sts_pkg::FIELD_W-1:0]   i_write_value,
    input  logic signed [sts_pkg::FIELD_W-1:0]   i_search_key,
    input  logic [sts_pkg::INDEX_W-1:0]          i_range_start,
    input  logic signed [sts_pkg::END_W-1:0]     i_range_end,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_found,
    output logic [sts_pkg::POS_W-1:0]            o_position,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sts_pkg::APB_AW-1:0]           paddr,
    input  logic [sts_pkg::APB_DW-1:0]           pwdata,
    output logic [sts_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int XW = IW + 2;
    localparam int CW = (IW + 1 > sts_pkg::COUNT_W) ? IW + 1 : sts_pkg::COUNT_W;
    localparam int VW = VALUE_WIDTH;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);

    sts_pkg::t_state r_state, n_state;

    logic [sts_pkg::COUNT_W-1:0] r_count;
    logic [VW-1:0]               r_key, n_key;
    logic signed [XW-1:0]        r_lo, n_lo;
    logic signed [XW-1:0]        r_hi, n_hi;
    logic signed [XW-1:0]        r_mid, n_mid;
    logic signed [XW-1:0]        r_i, n_i;
    logic signed [XW-1:0]        r_n, n_n;
    logic                        r_hit, n_hit;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_found, n_out_found;
    logic [sts_pkg::POS_W-1:0]   r_out_pos, n_out_pos;

    logic                 in_accept;
    logic                 cfg_write;
    logic signed [VW-1:0] key_sx;
    logic signed [VW-1:0] wval_sx;
    logic [VW-1:0]        key_b;
    logic [VW-1:0]        wval_b;
    logic [CW-1:0]        count_c;
    logic [CW-1:0]        n_clamp;
    logic [CW-1:0]        start_c;
    logic [CW-1:0]        end_c;
    logic [CW-1:0]        hi_c;
    logic                 range_empty;
    logic                 ram_we;
    logic [IW-1:0]        ram_raddr;
    logic [VW-1:0]        ram_rdata;
    logic signed [XW-1:0] probe_mid;
    logic                 cmp_eq;
    logic                 cmp_key_lt;

    // Values are kept with the sign bit flipped so that an unsigned compare
    // gives the signed order.
    assign key_sx  = VW'(i_search_key);
    assign wval_sx = VW'(i_write_value);
    assign key_b   = {~key_sx[VW-1], key_sx[VW-2:0]};
    assign wval_b  = {~wval_sx[VW-1], wval_sx[VW-2:0]};

    assign in_accept = i_valid && o_ready;
    assign o_ready   = (r_state == sts_pkg::ST_IDLE);

    assign ram_we = in_accept && (i_opcode == sts_pkg::OP_WRITE)
                    && (CW'(i_write_index) < DEPTH_C);

    assign count_c = CW'(r_count);
    assign n_clamp = (count_c > DEPTH_C) ? DEPTH_C : count_c;

    assign start_c     = CW'(i_range_start);
    assign end_c       = CW'(i_range_end[sts_pkg::END_W-2:0]);
    assign hi_c        = (end_c > LAST_C) ? LAST_C : end_c;
    assign range_empty = i_range_end[sts_pkg::END_W-1] || (start_c >= DEPTH_C);

    // Shared index arithmetic and value comparator.
    assign probe_mid  = r_lo + ((r_hi - r_lo) >>> 1);
    assign cmp_eq     = (ram_rdata == r_key);
    assign cmp_key_lt = (r_key < ram_rdata);

    always_comb begin
        case (r_state)
            sts_pkg::ST_BIN_PROBE: ram_raddr = probe_mid[IW-1:0];
            sts_pkg::ST_EXP_PROBE: ram_raddr = r_i[IW-1:0];
            default:               ram_raddr = '0;
        endcase
    end

    sts_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IW'(i_write_index)),
        .i_wdata (wval_b),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_i         = r_i;
        n_n         = r_n;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !i_ready;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;

        case (r_state)
            sts_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_key = key_b;
                    n_hit = 1'b0;
                    n_mid = '0;
                    n_n   = XW'(n_clamp);
                    n_lo  = XW'(start_c);
                    n_hi  = XW'(hi_c);
                    if (i_opcode == sts_pkg::OP_BIN_SEARCH) begin
                        n_state = range_empty ? sts_pkg::ST_DONE : sts_pkg::ST_BIN_PROBE;
                    end else if (i_opcode == sts_pkg::OP_EXP_SEARCH) begin
                        // Entry 0 is read in this cycle; an empty table skips it.
                        n_state = (n_clamp == '0) ? sts_pkg::ST_DONE
                                                  : sts_pkg::ST_EXP_FIRST;
                    end
                end
            end
            sts_pkg::ST_BIN_PROBE: begin
                if (r_lo <= r_hi) begin
                    n_mid   = probe_mid;
                    n_state = sts_pkg::ST_BIN_CMP;
                end else begin
                    n_state = sts_pkg::ST_DONE;
                end
            end
            sts_pkg::ST_BIN_CMP: begin
                if (cmp_eq) begin
                    n_hit   = 1'b1;
                    n_state = sts_pkg::ST_DONE;
                end else begin
                    if (cmp_key_lt) begin
                        n_hi = r_mid - XW'(1);
                    end else begin
                        n_lo = r_mid + XW'(1);
                    end
                    n_state = sts_pkg::ST_BIN_PROBE;
                end
            end
            sts_pkg::ST_EXP_FIRST: begin
                if (cmp_eq) begin
                    n_hit   = 1'b1;
                    n_mid   = '0;
                    n_state = sts_pkg::ST_DONE;
                end else begin
                    n_i     = XW'(1);
                    n_state = sts_pkg::ST_EXP_PROBE;
                end
            end
            sts_pkg::ST_EXP_PROBE: begin
                n_state = (r_i < r_n) ? sts_pkg::ST_EXP_CMP : sts_pkg::ST_EXP_SPLIT;
            end
            sts_pkg::ST_EXP_CMP: begin
                if (!cmp_key_lt) begin
                    n_i     = r_i <<< 1;
                    n_state = sts_pkg::ST_EXP_PROBE;
                end else begin
                    n_state = sts_pkg::ST_EXP_SPLIT;
                end
            end
            sts_pkg::ST_EXP_SPLIT: begin
                // The last interval never reaches past the valid entries.
                n_lo    = r_i >>> 1;
                n_hi    = (r_i < r_n - XW'(1)) ? r_i : r_n - XW'(1);
                n_state = sts_pkg::ST_BIN_PROBE;
            end
            sts_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_hit;
                    n_out_pos   = r_hit ? sts_pkg::POS_W'(r_mid) : '0;
                    n_state     = sts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sts_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_i         <= n_i;
        r_n         <= n_n;
        r_hit       <= n_hit;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
    end

    // Configuration port: register 0 holds element_count.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == 1'(sts_pkg::REG_ELEMENT_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (cfg_write) begin
            r_count <= pwdata[sts_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'(sts_pkg::REG_ELEMENT_COUNT))
                    ? sts_pkg::APB_DW'(r_count) : '0;

    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

endmodule

// ----- design/sts_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted table search port checker
// Watches the ports of the search block for result and handshake rules.
// ----------------------------------------------------------------------------
module sts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [sts_pkg::OPCODE_W-1:0]  i_opcode,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_found,
    input logic [sts_pkg::POS_W-1:0]     o_position,
    input logic                          pready
);

    // A miss always reports position zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_position == '0))
        else $error("miss result with nonzero position");

    // A stalled result transaction holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_found) && $stable(o_position)))
        else $error("stalled result changed");

    // A search occupies the sequencer for at least the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_opcode == sts_pkg::OP_BIN_SEARCH
                                || i_opcode == sts_pkg::OP_EXP_SEARCH)) |=> !o_ready)
        else $error("ready right after a search transaction");

    // A search result cannot appear in the cycle after the search is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_opcode == sts_pkg::OP_BIN_SEARCH
                                || i_opcode == sts_pkg::OP_EXP_SEARCH) && !o_valid)
        |=> !o_valid)
        else $error("result produced without search latency");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("configuration port not ready");

endmodule

bind sorted_table_exponential_search sts_checker u_sts_checker (.*);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Sorted table search testbench
// Loads the search table and runs binary and exponential searches at several
// element_count settings. Every accepted transaction goes through a predictor
// that mirrors the probe sequence, and the monitor compares each result with
// the oldest prediction. Both handshake sides idle at random, and in one phase
// the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;

    import sts_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int TABLE_LAST    = TABLE_DEPTH - 1;
    localparam int MAX_GAP       = 18;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 50;
    localparam int RANDOM_PHASES = 10;
    localparam int PRESSURE_PHASE = 2;
    localparam int SPREAD_STEP   = 1 << 25;

    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
    localparam logic [APB_AW-1:0]   COUNT_ADDR  = APB_AW'(4 * REG_ELEMENT_COUNT);

    localparam longint VALUE_MAX = 2147483647;
    localparam longint VALUE_MIN = -VALUE_MAX - 1;

    typedef enum int {
        FILL_SPREAD,
        FILL_CLUSTERED,
        FILL_SCRAMBLED
    } t_fill;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic [INDEX_W-1:0]        write_index;
        logic signed [FIELD_W-1:0] write_value;
        logic signed [FIELD_W-1:0] search_key;
        logic [INDEX_W-1:0]        range_start;
        logic signed [END_W-1:0]   range_end;
    } t_table_op;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_lookup;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [OPCODE_W-1:0]       i_opcode;
    logic [INDEX_W-1:0]        i_write_index;
    logic signed [FIELD_W-1:0] i_write_value;
    logic signed [FIELD_W-1:0] i_search_key;
    logic [INDEX_W-1:0]        i_range_start;
    logic signed [END_W-1:0]   i_range_end;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_found;
    logic [POS_W-1:0]          o_position;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    // Predictor state: table contents and element_count as the block sees them.
    logic signed [FIELD_W-1:0] shadow_table [TABLE_DEPTH];
    logic [COUNT_W-1:0]        shadow_count;
    // Table contents as they will be once every queued write has gone through.
    logic signed [FIELD_W-1:0] plan_table [TABLE_DEPTH];

    t_table_op pending_ops[$];
    t_lookup   awaited_lookups[$];
    t_table_op offered_op;

    int   send_wait;
    int   ready_wait;
    logic send_dense;
    logic recv_dense;
    logic hold_go;
    logic rx_hold;
    int   error_count = 0;
    int   cycle_count = 0;

    sorted_table_exponential_search #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .VALUE_WIDTH(FIELD_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_write_index(i_write_index),
        .i_write_value(i_write_value),
        .i_search_key (i_search_key),
        .i_range_start(i_range_start),
        .i_range_end  (i_range_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_position   (o_position),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic int draw_gap(logic dense);
        return dense ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Midpoint search over lo..hi with the end clamped to the last entry.
    function automatic logic probe_range(int lo, int hi, logic signed [FIELD_W-1:0] key,
                                         output logic [POS_W-1:0] pos);
        int mid;
        pos = '0;
        if (hi > TABLE_LAST) begin
            hi = TABLE_LAST;
        end
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_table[mid] == key) begin
                pos = POS_W'(mid);
                return 1'b1;
            end
            if (key < shadow_table[mid]) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_lookup(t_table_op op);
        t_lookup                   res;
        logic [POS_W-1:0]          pos;
        logic signed [FIELD_W-1:0] key;
        int                        n;
        int                        span;
        int                        hi;
        res = '0;
        pos = '0;
        key = op.search_key;
        case (op.opcode)
            OP_WRITE: begin
                shadow_table[op.write_index] = op.write_value;
                return;
            end
            OP_BIN_SEARCH: begin
                res.found = probe_range(int'(op.range_start), int'($signed(op.range_end)),
                                        key, pos);
                res.position = pos;
            end
            OP_EXP_SEARCH: begin
                n = (int'(shadow_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
                if (n == 0) begin
                    res.found = 1'b0;
                end else if (shadow_table[0] == key) begin
                    res.found = 1'b1;
                end else begin
                    span = 1;
                    while (span < n && shadow_table[span] <= key) begin
                        span = span * 2;
                    end
                    // The last interval never reaches past the valid entries.
                    hi = (span < n - 1) ? span : n - 1;
                    res.found = probe_range(span / 2, hi, key, pos);
                    res.position = pos;
                end
            end
            default: begin
                return;
            end
        endcase
        awaited_lookups.push_back(res);
    endfunction

    // Every field starts random so that unused fields toggle too.
    function automatic t_table_op noisy_op();
        t_table_op op;
        op.opcode      = OPCODE_W'($urandom_range(0, 3));
        op.write_index = INDEX_W'($urandom);
        op.write_value = $urandom;
        op.search_key  = $urandom;
        op.range_start = INDEX_W'($urandom);
        op.range_end   = END_W'($urandom);
        return op;
    endfunction

    function automatic void push_op(t_table_op op);
        if (op.opcode == OP_WRITE) begin
            plan_table[op.write_index] = op.write_value;
        end
        pending_ops.push_back(op);
    endfunction

    function automatic void queue_write(logic [INDEX_W-1:0] idx,
                                        logic signed [FIELD_W-1:0] value);
        t_table_op op;
        op = noisy_op();
        op.opcode      = OP_WRITE;
        op.write_index = idx;
        op.write_value = value;
        push_op(op);
    endfunction

    function automatic void queue_search(logic [OPCODE_W-1:0] opcode,
                                         logic signed [FIELD_W-1:0] key,
                                         int first, int last);
        t_table_op op;
        op = noisy_op();
        op.opcode      = opcode;
        op.search_key  = key;
        op.range_start = INDEX_W'(first);
        op.range_end   = END_W'(last);
        push_op(op);
    endfunction

    function automatic logic signed [FIELD_W-1:0] pick_key();
        logic signed [FIELD_W-1:0] hit;
        hit = plan_table[$urandom_range(0, TABLE_LAST)];
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return $urandom_range(0, 1) ? FIELD_W'(VALUE_MAX) : FIELD_W'(VALUE_MIN);
            3: return hit + 1;
            4: return hit - 1;
            default: return hit;
        endcase
    endfunction

    function automatic void load_table(t_fill style);
        longint level;
        level = (style == FILL_CLUSTERED) ? longint'($urandom_range(0, 2000)) - 1000 : 0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            case (style)
                FILL_SPREAD: begin
                    level = (k == 0) ? VALUE_MIN
                                     : level + longint'($urandom_range(0, SPREAD_STEP));
                end
                FILL_CLUSTERED: begin
                    level = level + longint'($urandom_range(0, 2));
                end
                default: begin
                    level = longint'($signed($urandom));
                end
            endcase
            if (level > VALUE_MAX || (style == FILL_SPREAD && k == TABLE_LAST)) begin
                level = VALUE_MAX;
            end
            queue_write(INDEX_W'(k), FIELD_W'(level));
        end
    endfunction

    // Returns once every queued transaction is in and every result is out.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_ops.size() != 0 || i_valid || awaited_lookups.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_element_count(int unsigned value);
        logic [APB_DW-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
        end while (!pready);
        @(posedge i_clk);
        shadow_count = COUNT_W'(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
        end while (!pready);
        got = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DW'(value)) begin
            report_mismatch($sformatf("element_count reads back %0d, wrote %0d", got, value));
        end
    endtask

    // Sender: one transaction per queue entry, with a drawn gap after each.
    always @(posedge i_clk) begin : op_driver
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_opcode      <= '0;
            i_write_index <= '0;
            i_write_value <= '0;
            i_search_key  <= '0;
            i_range_start <= '0;
            i_range_end   <= '0;
            send_wait     <= 0;
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                shadow_table[k] = '0;
            end
        end else begin
            if (i_valid && o_ready) begin
                predict_lookup(offered_op);
            end
            if (!i_valid || o_ready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    i_valid   <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    offered_op     = pending_ops.pop_front();
                    i_opcode      <= offered_op.opcode;
                    i_write_index <= offered_op.write_index;
                    i_write_value <= offered_op.write_value;
                    i_search_key  <= offered_op.search_key;
                    i_range_start <= offered_op.range_start;
                    i_range_end   <= offered_op.range_end;
                    i_valid       <= 1'b1;
                    send_wait     <= draw_gap(send_dense);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_lookup want;
        int      next_wait;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_wait <= 0;
        end else begin
            next_wait = (ready_wait > 0) ? ready_wait - 1 : 0;
            if (o_valid && i_ready) begin
                next_wait = draw_gap(recv_dense);
                if (awaited_lookups.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: found=%0b pos=%0d",
                                              o_found, o_position));
                end else begin
                    want = awaited_lookups.pop_front();
                    if (o_found !== want.found) begin
                        report_mismatch($sformatf("found is %0b, predicted %0b",
                                                  o_found, want.found));
                    end
                    if (o_position !== want.position) begin
                        report_mismatch($sformatf("position is %0d, predicted %0d",
                                                  o_position, want.position));
                    end
                end
            end
            ready_wait <= next_wait;
            i_ready    <= !rx_hold && next_wait == 0;
        end
    end

    // A long result stall, so that the output register fills and input backs up.
    initial begin : result_hold
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_table_op   op;
        int          roll;
        int unsigned next_count;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        shadow_count  = '0;
        send_dense    = 1'b0;
        recv_dense    = 1'b0;
        hold_go       = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            plan_table[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Whole table first, so no search ever touches an unwritten entry.
        load_table(FILL_SPREAD);
        queue_search(OP_EXP_SEARCH, plan_table[0], 0, 0);
        queue_search(OP_BIN_SEARCH, plan_table[0], 0, TABLE_LAST);
        queue_search(OP_BIN_SEARCH, plan_table[TABLE_LAST], 0, TABLE_LAST);
        queue_search(OP_BIN_SEARCH, plan_table[100], 0, -1);
        queue_search(OP_BIN_SEARCH, plan_table[100], 101, 100);
        queue_search(OP_BIN_SEARCH, plan_table[100], 100, 100);
        queue_search(OP_BIN_SEARCH, plan_table[100], TABLE_LAST, -256);
        queue_search(OP_BIN_SEARCH, plan_table[200], 0, 127);
        queue_search(OP_RESERVED, plan_table[5], 0, TABLE_LAST);
        queue_write(INDEX_W'(TABLE_LAST), FIELD_W'(VALUE_MAX));
        queue_write('0, FIELD_W'(VALUE_MIN));
        queue_search(OP_BIN_SEARCH, FIELD_W'(VALUE_MAX), 0, TABLE_LAST);
        queue_search(OP_BIN_SEARCH, FIELD_W'(VALUE_MIN), 0, TABLE_LAST);
        wait_idle();

        set_element_count(1);
        queue_search(OP_EXP_SEARCH, plan_table[0], 0, 0);
        queue_search(OP_EXP_SEARCH, plan_table[1], 0, 0);
        wait_idle();
        set_element_count(TABLE_DEPTH);
        queue_search(OP_EXP_SEARCH, plan_table[TABLE_LAST], 0, 0);
        queue_search(OP_EXP_SEARCH, plan_table[0], 0, 0);
        queue_search(OP_EXP_SEARCH, plan_table[200], 0, 0);
        queue_search(OP_EXP_SEARCH, plan_table[200] + 1, 0, 0);
        wait_idle();
        set_element_count(511);
        queue_search(OP_EXP_SEARCH, plan_table[TABLE_LAST], 0, 0);
        queue_search(OP_EXP_SEARCH, plan_table[37], 0, 0);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0, 2, 7: next_count = TABLE_DEPTH;
                1: next_count = 2;
                3: next_count = 3;
                4: next_count = 100;
                5: next_count = 511;
                6: next_count = 129;
                8: next_count = 1;
                default: next_count = $urandom_range(0, 511);
            endcase
            set_element_count(next_count);
            case (ph)
                1: load_table(FILL_CLUSTERED);
                3: load_table(FILL_SCRAMBLED);
                4: load_table(FILL_SPREAD);
                default: ;
            endcase
            send_dense = ($urandom_range(0, 3) == 0);
            recv_dense = ($urandom_range(0, 3) == 0);
            if (ph == PRESSURE_PHASE) begin
                send_dense = 1'b1;
                hold_go    = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                op   = noisy_op();
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    // A stray write may leave the table out of order.
                    op.opcode = OP_WRITE;
                end else if (roll < 9) begin
                    op.opcode = OP_RESERVED;
                end else if (roll < 50) begin
                    op.opcode     = OP_EXP_SEARCH;
                    op.search_key = pick_key();
                end else begin
                    op.opcode     = OP_BIN_SEARCH;
                    op.search_key = pick_key();
                    if (roll < 65) begin
                        op.range_start = '0;
                        op.range_end   = END_W'(TABLE_LAST);
                    end else if (roll < 95) begin
                        op.range_end = END_W'(int'(op.range_start)
                                       + int'($urandom_range(0, TABLE_LAST - op.range_start)));
                    end
                end
                push_op(op);
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
